// ===== design/scta_pkg.sv =====
package scta_pkg;

  localparam int TABLE_ROWS    = 256;
  localparam int TABLE_COLS    = 3;
  localparam int TABLE_ENTRIES = TABLE_ROWS * TABLE_COLS;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

  localparam int MAX_RESULTS          = 32;
  localparam int DEFAULT_BUFFER_DEPTH = 32;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  localparam logic [7:0] RST_ALT_PRESS     = 8'd128;
  localparam logic [7:0] RST_SHIFT_PRESS   = 8'd129;
  localparam logic [7:0] RST_SHIFT_RELEASE = 8'd130;
  localparam logic [7:0] RST_ALT_RELEASE   = 8'd131;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [3:0] CFG_ALT_PRESS     = 4'd0;
  localparam logic [3:0] CFG_SHIFT_PRESS   = 4'd1;
  localparam logic [3:0] CFG_SHIFT_RELEASE = 4'd2;
  localparam logic [3:0] CFG_ALT_RELEASE   = 4'd3;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SHIFT = 2'd1;
  localparam logic [1:0] MODE_ALT   = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SCAN,
    OP_DRAIN
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DRAIN,
    ST_DRAIN_WAIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] row;
    logic [1:0] col;
    logic [7:0] data;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] alt_press;
    logic [7:0] shift_press;
    logic [7:0] shift_release;
    logic [7:0] alt_release;
  } cfg_codes_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_to_front_t;

  // row * 3 + col
  function automatic logic [TBL_AW-1:0] table_addr(input logic [7:0] row,
                                                   input logic [1:0] col);
    table_addr = TBL_AW'({2'b00, row}) + TBL_AW'({1'b0, row, 1'b0}) + TBL_AW'(col);
  endfunction

endpackage

// ===== design/scta_ram.sv =====
module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/scta_front.sv =====
module scta_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               command,
  input  logic [7:0]               scan_value,
  input  logic [1:0]               table_mode,
  input  logic [7:0]               entry_char,
  input  logic [5:0]               read_count,
  input  scta_pkg::back_to_front_t ctl,
  output logic                     q_valid,
  output scta_pkg::cmd_t           q_item
);

  scta_pkg::cmd_t slots [scta_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  scta_pkg::cmd_t cls;
  logic           keep;
  logic           push;

  // classify: table writes to column 3 and unknown commands are dropped here
  always_comb begin
    cls.row   = scan_value;
    cls.col   = table_mode;
    cls.data  = entry_char;
    cls.count = read_count;
    cls.op    = scta_pkg::OP_WRITE;
    keep      = 1'b0;
    unique case (command)
      scta_pkg::CMD_WRITE: begin
        cls.op = scta_pkg::OP_WRITE;
        keep   = (table_mode < 2'(scta_pkg::TABLE_COLS));
      end
      scta_pkg::CMD_SCAN: begin
        cls.op = scta_pkg::OP_SCAN;
        keep   = 1'b1;
      end
      scta_pkg::CMD_DRAIN: begin
        cls.op = scta_pkg::OP_DRAIN;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_stall = ctl.clearing || (count == 2'(scta_pkg::QUEUE_DEPTH));
  assign push       = item_valid && !item_stall && keep;
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rd_ptr];

  always_comb begin
    count_next = count + 2'(push) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (ctl.pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (count != 2'd0))
    else $error("queue pop while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(scta_pkg::QUEUE_DEPTH)) |-> !push)
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(scta_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/scta_back.sv =====
module scta_back #(
  parameter int BUFFER_DEPTH = scta_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  scta_pkg::cmd_t           q_item,
  input  scta_pkg::cfg_codes_t     codes,
  output scta_pkg::back_to_front_t ctl,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     has_char,
  output logic [6:0]               char_out,
  output logic                     is_last
);

  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int TBL_AW = scta_pkg::TBL_AW;

  scta_pkg::state_t  state, state_next;
  logic [1:0]        mode, mode_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [TBL_AW-1:0] clear_addr, clear_addr_next;
  logic [5:0]        drain_n, drain_n_next;
  logic [5:0]        drain_idx, drain_idx_next;
  logic              out_valid, out_valid_next;
  logic              out_has, out_has_next;
  logic [6:0]        out_char, out_char_next;
  logic              out_last, out_last_next;

  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [7:0]        tbl_wdata, tbl_rdata;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [6:0]        buf_wdata, buf_rdata;

  logic              out_free;
  logic [6:0]        rc7, fc7, n7;
  logic              pop;
  logic [7:0]        v;

  scta_ram #(.WIDTH(8), .DEPTH(scta_pkg::TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  scta_ram #(.WIDTH(7), .DEPTH(BUFFER_DEPTH)) u_chars (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  assign out_free = !out_valid || !result_stall;
  assign v        = tbl_rdata;

  // characters a drain returns: min(read_count, fill_count, MAX_RESULTS)
  always_comb begin
    rc7 = {1'b0, q_item.count};
    fc7 = 7'(fill_count);
    n7  = (rc7 < fc7) ? rc7 : fc7;
    if (n7 > 7'(scta_pkg::MAX_RESULTS)) begin
      n7 = 7'(scta_pkg::MAX_RESULTS);
    end
  end

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    fill_count_next = fill_count;
    clear_addr_next = clear_addr;
    drain_n_next    = drain_n;
    drain_idx_next  = drain_idx;
    out_valid_next  = out_valid && result_stall;
    out_has_next    = out_has;
    out_char_next   = out_char;
    out_last_next   = out_last;
    pop             = 1'b0;
    tbl_we          = 1'b0;
    tbl_waddr       = scta_pkg::table_addr(q_item.row, q_item.col);
    tbl_wdata       = q_item.data;
    tbl_re          = 1'b0;
    tbl_raddr       = scta_pkg::table_addr(q_item.row, mode);
    buf_we          = 1'b0;
    buf_waddr       = fill_count[BUF_AW-1:0];
    buf_wdata       = v[6:0];
    buf_re          = 1'b0;
    buf_raddr       = drain_idx[BUF_AW-1:0];

    unique case (state)
      scta_pkg::ST_CLEAR: begin
        tbl_we          = 1'b1;
        tbl_waddr       = clear_addr;
        tbl_wdata       = 8'd0;
        clear_addr_next = clear_addr + TBL_AW'(1);
        if (clear_addr == TBL_AW'(scta_pkg::TABLE_ENTRIES - 1)) begin
          state_next = scta_pkg::ST_IDLE;
        end
      end
      scta_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            scta_pkg::OP_WRITE: begin
              tbl_we = 1'b1;
              pop    = 1'b1;
            end
            scta_pkg::OP_SCAN: begin
              tbl_re     = 1'b1;
              pop        = 1'b1;
              state_next = scta_pkg::ST_LOOKUP;
            end
            scta_pkg::OP_DRAIN: begin
              if (n7 == 7'd0) begin
                if (out_free) begin
                  pop             = 1'b1;
                  fill_count_next = '0;
                  out_valid_next  = 1'b1;
                  out_has_next    = 1'b0;
                  out_char_next   = 7'd0;
                  out_last_next   = 1'b1;
                end
              end else begin
                pop             = 1'b1;
                fill_count_next = '0;
                drain_n_next    = 6'(n7);
                drain_idx_next  = 6'd0;
                state_next      = scta_pkg::ST_DRAIN;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      scta_pkg::ST_LOOKUP: begin
        state_next = scta_pkg::ST_IDLE;
        // first match wins when special codes collide
        priority if (v == codes.alt_press) begin
          mode_next = scta_pkg::MODE_ALT;
        end else if (v == codes.shift_press) begin
          mode_next = scta_pkg::MODE_SHIFT;
        end else if (v == codes.shift_release || v == codes.alt_release) begin
          mode_next = scta_pkg::MODE_PLAIN;
        end else if (v >= scta_pkg::PRINT_LOW && v <= scta_pkg::PRINT_HIGH &&
                     fill_count < CNT_W'(BUFFER_DEPTH)) begin
          buf_we          = 1'b1;
          fill_count_next = fill_count + CNT_W'(1);
        end else begin
          mode_next = mode;
        end
      end
      scta_pkg::ST_DRAIN: begin
        // start the read only when the output register is free next cycle
        if (out_free) begin
          buf_re     = 1'b1;
          state_next = scta_pkg::ST_DRAIN_WAIT;
        end
      end
      scta_pkg::ST_DRAIN_WAIT: begin
        out_valid_next = 1'b1;
        out_has_next   = 1'b1;
        out_char_next  = buf_rdata;
        out_last_next  = (drain_idx + 6'd1 == drain_n);
        drain_idx_next = drain_idx + 6'd1;
        state_next     = (drain_idx + 6'd1 == drain_n) ? scta_pkg::ST_IDLE
                                                       : scta_pkg::ST_DRAIN;
      end
      default: begin
        state_next = scta_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scta_pkg::ST_CLEAR;
      mode       <= scta_pkg::MODE_PLAIN;
      fill_count <= '0;
      clear_addr <= '0;
      drain_n    <= 6'd0;
      drain_idx  <= 6'd0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      fill_count <= fill_count_next;
      clear_addr <= clear_addr_next;
      drain_n    <= drain_n_next;
      drain_idx  <= drain_idx_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_has  <= out_has_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign ctl.pop      = pop;
  assign ctl.clearing = (state == scta_pkg::ST_CLEAR);
  assign result_valid = out_valid;
  assign has_char     = out_has;
  assign char_out     = out_char;
  assign is_last      = out_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == scta_pkg::ST_DRAIN_WAIT) |-> !out_valid)
    else $error("drain read lands on an occupied output register");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == scta_pkg::ST_CLEAR) |-> !pop)
    else $error("queue popped during table clear");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == scta_pkg::ST_DRAIN || state == scta_pkg::ST_DRAIN_WAIT) |->
    (drain_idx < drain_n))
    else $error("drain index past drain length");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == scta_pkg::ST_DRAIN_WAIT && drain_idx + 6'd1 == drain_n) |=>
    (state == scta_pkg::ST_IDLE && out_valid && out_last))
    else $error("final drain transfer not marked last");

endmodule

// ===== design/scan_code_to_ascii_buffer_top.sv =====
// Channel   Handshake               Payload
// item      item_valid/item_stall   command, scan_value, table_mode, entry_char, read_count
// result    result_valid/result_stall  has_char, char_out, is_last
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data (ready is always high)
//
// Table write: done in the back end when popped. Scan: the table read is registered.
// Drain: each character is read from the character store, then loaded into the output
// register; an empty drain loads it directly. A 2-entry queue sits between the front
// and back ends; output is one register. After reset the 768-entry key table is zeroed,
// one entry per cycle, with item_stall high. Config writes are taken during that pass.
module scan_code_to_ascii_buffer_top #(
  parameter int BUFFER_DEPTH = scta_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] command,
  input  logic [7:0] scan_value,
  input  logic [1:0] table_mode,
  input  logic [7:0] entry_char,
  input  logic [5:0] read_count,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       has_char,
  output logic [6:0] char_out,
  output logic       is_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [7:0] cfg_data
);

  scta_pkg::cfg_codes_t     codes;
  scta_pkg::back_to_front_t ctl;
  scta_pkg::cmd_t           q_item;
  logic                     q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.alt_press     <= scta_pkg::RST_ALT_PRESS;
      codes.shift_press   <= scta_pkg::RST_SHIFT_PRESS;
      codes.shift_release <= scta_pkg::RST_SHIFT_RELEASE;
      codes.alt_release   <= scta_pkg::RST_ALT_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scta_pkg::CFG_ALT_PRESS:     codes.alt_press     <= cfg_data;
        scta_pkg::CFG_SHIFT_PRESS:   codes.shift_press   <= cfg_data;
        scta_pkg::CFG_SHIFT_RELEASE: codes.shift_release <= cfg_data;
        scta_pkg::CFG_ALT_RELEASE:   codes.alt_release   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  scta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .scan_value (scan_value),
    .table_mode (table_mode),
    .entry_char (entry_char),
    .read_count (read_count),
    .ctl        (ctl),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  scta_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .codes        (codes),
    .ctl          (ctl),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .has_char     (has_char),
    .char_out     (char_out),
    .is_last      (is_last)
  );

endmodule
